@@ rtl/core/byte_budget_lru_cache_macros.svh @@
// Assertion macros used by the checker of the byte budget LRU cache.
`ifndef BYTE_BUDGET_LRU_CACHE_MACROS_SVH
`define BYTE_BUDGET_LRU_CACHE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BBLRU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BBLRU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/bblru_pkg.sv @@
// Types, constants and helper functions of the byte budget LRU cache.
`default_nettype none

package bblru_pkg;

  // Field widths.
  localparam int unsigned TAG_W       = 16;
  localparam int unsigned SIZE_W      = 20;
  localparam int unsigned BYTES_W     = 32;
  localparam int unsigned COUNT_OUT_W = 7;

  // Default number of cache entries.
  localparam int unsigned DEFAULT_ENTRIES = 64;

  // Configuration port.
  localparam int unsigned PADDR_W = 2;
  localparam logic [PADDR_W-1:0] ADDR_BYTE_BUDGET = '0;
  localparam logic [BYTES_W-1:0] BUDGET_RESET = 32'd1048576;

  // Controller states.
  typedef enum logic {
    ST_IDLE,
    ST_UPDATE
  } state_e;

  // One entry as held in a cell and handed to the next cell.
  typedef struct packed {
    logic              valid;
    logic              tail;
    logic [TAG_W-1:0]  tag;
    logic [SIZE_W-1:0] size;
  } cell_data_t;

  // Controls broadcast to every cell.
  typedef struct packed {
    logic accept;   // latch the tag compare for a new item
    logic upd_hit;  // move the hit entry to the head
    logic upd_ins;  // push a new entry in at the head
    logic evict;    // drop the tail entry while pushing
  } cell_ctrl_t;

  // Saturating add of an entry size to the byte total.
  function automatic logic [BYTES_W-1:0] sat_add(input logic [BYTES_W-1:0] a,
                                                 input logic [SIZE_W-1:0]  b);
    logic [BYTES_W:0] sum;
    sum = {1'b0, a} + {{(BYTES_W - SIZE_W + 1){1'b0}}, b};
    return sum[BYTES_W] ? '1 : sum[BYTES_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/byte_budget_lru_cache.sv @@
// Top level of the byte budget LRU glyph cache: controller, accumulators and cell chain.
//
//   channel   ports                                      direction  handshake
//   request   glyph_index_i, entry_bytes_i, render_ok_i  in         start, busy
//   result    hit_o .. entry_count_o                     out        done_o strobe
//   config    psel, penable, pwrite, paddr, pwdata       in/out     APB, pready high
//
// An item is taken at the accept edge, which compares the tag in every cell and
// latches the budget check; the next edge shifts the cell row and updates
// the totals. busy is high only in between, in the update state; the result strobe
// shows in the following cycle, while a new start can already be accepted.
// Reset clears all cell valid bits at once; no clearing pass is needed.
// The receiver cannot stall: each result is shown for one cycle only.
`default_nettype none

module byte_budget_lru_cache #(
  parameter int unsigned ENTRIES = bblru_pkg::DEFAULT_ENTRIES
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Request
  input  logic                              start,
  output logic                              busy,
  input  logic [bblru_pkg::TAG_W-1:0]       glyph_index_i,
  input  logic [bblru_pkg::SIZE_W-1:0]      entry_bytes_i,
  input  logic                              render_ok_i,
  // Result
  output logic                              done_o,
  output logic                              hit_o,
  output logic                              inserted_o,
  output logic                              evicted_o,
  output logic [bblru_pkg::TAG_W-1:0]       evicted_index_o,
  output logic [bblru_pkg::BYTES_W-1:0]     bytes_used_o,
  output logic [bblru_pkg::COUNT_OUT_W-1:0] entry_count_o,
  // Configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bblru_pkg::PADDR_W-1:0]     paddr,
  input  logic [bblru_pkg::BYTES_W-1:0]     pwdata,
  output logic [bblru_pkg::BYTES_W-1:0]     prdata,
  output logic                              pready
);
  import bblru_pkg::*;

  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam logic [CW-1:0] FullCount = CW'(ENTRIES);

  state_e state_q, state_d;

  logic [BYTES_W-1:0] budget_q;
  logic [BYTES_W-1:0] total_q, total_d;
  logic [CW-1:0]      count_q, count_d;
  logic               done_q;

  // Item captured at accept.
  logic [TAG_W-1:0]   glyph_q;
  logic [SIZE_W-1:0]  bytes_q;
  logic               ok_q;
  logic               over_q;
  logic               full_q;
  logic [TAG_W-1:0]   tail_tag_q;
  logic [BYTES_W-1:0] total_less_tail_q;

  // Result payload.
  logic               hit_q, ins_q, ev_q;
  logic [TAG_W-1:0]   ev_idx_q;

  logic               accept;
  logic               in_update;
  logic               hit;
  logic               ins;
  logic               ev;
  logic               over;
  logic [BYTES_W:0]   sum_with_new;
  logic [BYTES_W-1:0] tail_size_ext;
  logic [BYTES_W-1:0] total_less_tail;

  cell_ctrl_t         ctrl;
  cell_data_t         head_data;
  cell_data_t         slot_data [ENTRIES];
  logic [ENTRIES-1:0] match_vec;
  logic [ENTRIES-1:0] tail_vec;
  logic [ENTRIES:0]   hb_chain;
  logic [ENTRIES-1:0] tag_col  [TAG_W];
  logic [ENTRIES-1:0] size_col [SIZE_W];
  logic [TAG_W-1:0]   tail_tag;
  logic [SIZE_W-1:0]  tail_size;
  logic [SIZE_W-1:0]  hit_size;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (start) state_d = ST_UPDATE;
      ST_UPDATE: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    busy      = 1'b0;
    in_update = 1'b0;
    case (state_q)
      ST_IDLE:   busy = 1'b0;
      ST_UPDATE: begin
        busy      = 1'b1;
        in_update = 1'b1;
      end
      default:   busy = 1'b0;
    endcase
  end

  assign accept = start & ~busy;

  // Cell chain.
  assign hb_chain[0] = 1'b0;

  for (genvar k = 0; k < ENTRIES; k++) begin : g_slot
    cell_data_t prev;
    logic       next_valid;

    if (k == 0) begin : g_head
      assign prev = head_data;
    end else begin : g_link
      assign prev = slot_data[k-1];
    end

    if (k == ENTRIES - 1) begin : g_last
      assign next_valid = 1'b0;
    end else begin : g_mid
      assign next_valid = slot_data[k+1].valid;
    end

    bblru_cell u_slot (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .key_i        (glyph_index_i),
      .prev_i       (prev),
      .next_valid_i (next_valid),
      .hit_before_i (hb_chain[k]),
      .data_o       (slot_data[k]),
      .match_o      (match_vec[k]),
      .hit_before_o (hb_chain[k+1])
    );

    assign tail_vec[k] = slot_data[k].tail;

    for (genvar b = 0; b < TAG_W; b++) begin : g_tag_bit
      assign tag_col[b][k] = slot_data[k].tag[b];
    end
    for (genvar b = 0; b < SIZE_W; b++) begin : g_size_bit
      assign size_col[b][k] = slot_data[k].size[b];
    end
  end

  // One-hot selection of the tail entry and of the hit entry.
  for (genvar b = 0; b < TAG_W; b++) begin : g_tail_tag
    assign tail_tag[b] = |(tag_col[b] & tail_vec);
  end
  for (genvar b = 0; b < SIZE_W; b++) begin : g_sel_size
    assign tail_size[b] = |(size_col[b] & tail_vec);
    assign hit_size[b]  = |(size_col[b] & match_vec);
  end

  // Budget check and the byte total once the tail is gone, taken at accept.
  assign sum_with_new    = {1'b0, total_q} + {{(BYTES_W - SIZE_W + 1){1'b0}}, entry_bytes_i};
  assign over            = (count_q != '0) && (sum_with_new > {1'b0, budget_q});
  assign tail_size_ext   = {{(BYTES_W - SIZE_W){1'b0}}, tail_size};
  assign total_less_tail = (total_q >= tail_size_ext) ? (total_q - tail_size_ext) : '0;

  // Decision in the update cycle.
  assign hit = |match_vec;
  assign ins = ~hit & ok_q;
  assign ev  = ins & (over_q | full_q);

  assign ctrl.accept  = accept;
  assign ctrl.upd_hit = in_update & hit;
  assign ctrl.upd_ins = in_update & ins;
  assign ctrl.evict   = in_update & ev;

  // Entry offered to the head cell.
  assign head_data.valid = 1'b1;
  assign head_data.tail  = 1'b0;
  assign head_data.tag   = glyph_q;
  assign head_data.size  = hit ? hit_size : bytes_q;

  // Totals after the item.
  always_comb begin
    total_d = total_q;
    count_d = count_q;
    if (in_update && ins) begin
      total_d = sat_add(ev ? total_less_tail_q : total_q, bytes_q);
      count_d = ev ? count_q : count_q + CW'(1);
    end
  end

  // Control state and accumulators.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      budget_q <= BUDGET_RESET;
      total_q  <= '0;
      count_q  <= '0;
      done_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      total_q <= total_d;
      count_q <= count_d;
      done_q  <= in_update;
      if (psel && penable && pwrite && pready && (paddr == ADDR_BYTE_BUDGET)) begin
        budget_q <= pwdata;
      end
    end
  end

  // Item and result payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      glyph_q           <= glyph_index_i;
      bytes_q           <= entry_bytes_i;
      ok_q              <= render_ok_i;
      over_q            <= over;
      full_q            <= (count_q == FullCount);
      tail_tag_q        <= tail_tag;
      total_less_tail_q <= total_less_tail;
    end
    if (in_update) begin
      hit_q    <= hit;
      ins_q    <= ins;
      ev_q     <= ev;
      ev_idx_q <= ev ? tail_tag_q : '0;
    end
  end

  // Result ports.
  assign done_o          = done_q;
  assign hit_o           = hit_q;
  assign inserted_o      = ins_q;
  assign evicted_o       = ev_q;
  assign evicted_index_o = ev_idx_q;
  assign bytes_used_o    = total_q;

  if (CW >= COUNT_OUT_W) begin : g_count_trunc
    assign entry_count_o = count_q[COUNT_OUT_W-1:0];
  end else begin : g_count_ext
    assign entry_count_o = {{(COUNT_OUT_W - CW){1'b0}}, count_q};
  end

  // Register read-back.
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_BYTE_BUDGET) ? budget_q : '0;

endmodule

`default_nettype wire

@@ rtl/core/bblru_cell.sv @@
// One cell of the recency chain: holds one entry and takes its neighbor's on a shift.
`default_nettype none

module bblru_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bblru_pkg::cell_ctrl_t         ctrl_i,
  input  logic [bblru_pkg::TAG_W-1:0]   key_i,
  input  bblru_pkg::cell_data_t         prev_i,
  input  logic                          next_valid_i,
  input  logic                          hit_before_i,
  output bblru_pkg::cell_data_t         data_o,
  output logic                          match_o,
  output logic                          hit_before_o
);
  import bblru_pkg::*;

  logic              valid_q, valid_d;
  logic              match_q, match_d;
  logic [TAG_W-1:0]  tag_q, tag_d;
  logic [SIZE_W-1:0] size_q, size_d;
  logic              shift;

  // On an insert every cell shifts; on a hit only the cells up to the hit one.
  assign shift = ctrl_i.upd_ins | (ctrl_i.upd_hit & ~hit_before_i);

  // Next contents: the neighbor's entry, with the evicted tail dropped.
  always_comb begin
    valid_d = valid_q;
    tag_d   = tag_q;
    size_d  = size_q;
    match_d = match_q;
    if (shift) begin
      valid_d = prev_i.valid & ~(ctrl_i.evict & prev_i.tail);
      tag_d   = prev_i.tag;
      size_d  = prev_i.size;
    end
    if (ctrl_i.accept) begin
      match_d = valid_q && (tag_q == key_i);
    end
  end

  // Control bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      match_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      match_q <= match_d;
    end
  end

  // Entry payload.
  always_ff @(posedge clk_i) begin
    tag_q  <= tag_d;
    size_q <= size_d;
  end

  // Valid entries are packed from the head, so the tail is the last valid one.
  assign data_o.valid = valid_q;
  assign data_o.tail  = valid_q & ~next_valid_i;
  assign data_o.tag   = tag_q;
  assign data_o.size  = size_q;

  assign match_o      = match_q;
  assign hit_before_o = hit_before_i | match_q;

endmodule

`default_nettype wire

@@ rtl/core/bblru_checker.sv @@
// Port-level checker of the byte budget LRU cache, bound to the top level.
`default_nettype none
`include "byte_budget_lru_cache_macros.svh"

module bblru_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              start,
  input logic                              busy,
  input logic                              done_o,
  input logic                              hit_o,
  input logic                              inserted_o,
  input logic                              evicted_o,
  input logic [bblru_pkg::TAG_W-1:0]       evicted_index_o,
  input logic [bblru_pkg::BYTES_W-1:0]     bytes_used_o,
  input logic [bblru_pkg::COUNT_OUT_W-1:0] entry_count_o
);

  // An accepted item occupies the block for exactly one update cycle.
  `BBLRU_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !done_o, "accept did not raise busy")

  // The result follows the update cycle directly.
  `BBLRU_ASSERT_NEXT(a_busy_done, busy, done_o && !busy, "no result after update cycle")

  // A hit neither inserts nor evicts.
  `BBLRU_ASSERT_NOW(a_hit_alone, done_o && hit_o, !inserted_o && !evicted_o && (evicted_index_o == '0), "hit changed the contents")

  // An eviction only makes room for an insert.
  `BBLRU_ASSERT_NOW(a_evict_insert, done_o && evicted_o, inserted_o, "eviction without insert")

  // Without an insert the totals stay as they were.
  `BBLRU_ASSERT_NOW(a_totals_hold, done_o && !inserted_o, (entry_count_o == $past(entry_count_o)) && (bytes_used_o == $past(bytes_used_o)), "totals changed without insert")

endmodule

bind byte_budget_lru_cache bblru_checker u_bblru_checker (.*);

`default_nettype wire

@@ dv/byte_budget_lru_cache_test.sv @@
// Self-checking testbench of the byte budget LRU glyph cache, with its own cache predictor.
module byte_budget_lru_cache_test;
  import bblru_pkg::*;

  localparam int unsigned ENTRIES = DEFAULT_ENTRIES;
  localparam int RANDOM_ITEMS = 300;
  // No correct run goes this long without moving an item, a result or a register access.
  localparam int STALL_LIMIT = 1000;

  typedef struct packed {
    logic                   hit;
    logic                   inserted;
    logic                   evicted;
    logic [TAG_W-1:0]       evicted_index;
    logic [BYTES_W-1:0]     bytes_used;
    logic [COUNT_OUT_W-1:0] entry_count;
  } lookup_result_t;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [TAG_W-1:0] glyph_index_i = '0;
  logic [SIZE_W-1:0] entry_bytes_i = '0;
  logic render_ok_i = 1'b0;
  logic done_o;
  logic hit_o;
  logic inserted_o;
  logic evicted_o;
  logic [TAG_W-1:0] evicted_index_o;
  logic [BYTES_W-1:0] bytes_used_o;
  logic [COUNT_OUT_W-1:0] entry_count_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [BYTES_W-1:0] pwdata = '0;
  logic [BYTES_W-1:0] prdata;
  logic pready;

  // Predicted cache contents and configuration.
  logic [TAG_W-1:0] cache_tag [ENTRIES];
  logic [SIZE_W-1:0] cache_size [ENTRIES];
  bit cache_valid [ENTRIES];
  int cache_rank [ENTRIES];
  int cached_count = 0;
  logic [BYTES_W-1:0] cached_bytes = '0;
  logic [BYTES_W-1:0] budget_model = BUDGET_RESET;

  lookup_result_t expected_lookups [$];
  int error_count = 0;
  int idle_pct = 30;
  int stall_cycles = 0;

  byte_budget_lru_cache #(.ENTRIES(ENTRIES)) DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start(start),
    .busy(busy),
    .glyph_index_i(glyph_index_i),
    .entry_bytes_i(entry_bytes_i),
    .render_ok_i(render_ok_i),
    .done_o(done_o),
    .hit_o(hit_o),
    .inserted_o(inserted_o),
    .evicted_o(evicted_o),
    .evicted_index_o(evicted_index_o),
    .bytes_used_o(bytes_used_o),
    .entry_count_o(entry_count_o),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Apply one lookup to the predicted cache and return the result it should report.
  function automatic lookup_result_t predict_lookup(input logic [TAG_W-1:0] glyph,
                                                    input logic [SIZE_W-1:0] nbytes,
                                                    input logic ok);
    lookup_result_t res;
    int hit_slot;
    int victim;
    int free_slot;
    int hit_rank;
    bit over_budget;
    logic [BYTES_W:0] sum;
    res = '0;
    hit_slot = -1;
    victim = -1;
    free_slot = -1;
    for (int i = 0; i < ENTRIES; i++)
      if (hit_slot < 0 && cache_valid[i] && cache_tag[i] == glyph) hit_slot = i;
    if (hit_slot >= 0) begin
      // A hit only moves the entry to the most recent position.
      res.hit = 1'b1;
      hit_rank = cache_rank[hit_slot];
      for (int i = 0; i < ENTRIES; i++)
        if (cache_valid[i] && cache_rank[i] < hit_rank) cache_rank[i]++;
      cache_rank[hit_slot] = 0;
    end else if (ok) begin
      over_budget = cached_count > 0 &&
                    ({1'b0, cached_bytes} + (BYTES_W+1)'(nbytes)) > {1'b0, budget_model};
      // At most one eviction, of the least recent entry.
      if (over_budget || cached_count >= ENTRIES) begin
        for (int i = 0; i < ENTRIES; i++)
          if (cache_valid[i] && (victim < 0 || cache_rank[i] >= cache_rank[victim])) victim = i;
        if (victim >= 0) begin
          cache_valid[victim] = 1'b0;
          if (cached_count > 0) cached_count--;
          cached_bytes = (cached_bytes >= cache_size[victim]) ?
                         cached_bytes - cache_size[victim] : '0;
          res.evicted = 1'b1;
          res.evicted_index = cache_tag[victim];
        end
      end
      for (int i = 0; i < ENTRIES; i++)
        if (free_slot < 0 && !cache_valid[i]) free_slot = i;
      // The new entry goes in even if the total stays over budget.
      if (free_slot >= 0) begin
        for (int i = 0; i < ENTRIES; i++)
          if (cache_valid[i]) cache_rank[i]++;
        cache_tag[free_slot] = glyph;
        cache_size[free_slot] = nbytes;
        cache_rank[free_slot] = 0;
        cache_valid[free_slot] = 1'b1;
        cached_count++;
        sum = {1'b0, cached_bytes} + (BYTES_W+1)'(nbytes);
        cached_bytes = sum[BYTES_W] ? '1 : sum[BYTES_W-1:0];
        res.inserted = 1'b1;
      end
    end
    res.bytes_used = cached_bytes;
    res.entry_count = COUNT_OUT_W'(cached_count);
    return res;
  endfunction

  // Offer one item, wait for it to be taken, then idle for a random number of cycles.
  task automatic send_lookup(input logic [TAG_W-1:0] glyph, input logic [SIZE_W-1:0] nbytes,
                             input logic ok);
    int gap;
    start <= 1'b1;
    glyph_index_i <= glyph;
    entry_bytes_i <= nbytes;
    render_ok_i <= ok;
    do @(posedge clk_i); while (busy);
    expected_lookups.push_back(predict_lookup(glyph, nbytes, ok));
    gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stop sending and let every outstanding result come back.
  task automatic wait_cache_idle();
    start <= 1'b0;
    while (expected_lookups.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // One APB transfer to the budget register; setup cycle, then access until ready.
  task automatic apb_transfer(input logic is_write, input logic [BYTES_W-1:0] wdata,
                              output logic [BYTES_W-1:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= is_write;
    paddr <= ADDR_BYTE_BUDGET;
    pwdata <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Compare a register read with the value the register should hold.
  task automatic check_budget_read(input logic [BYTES_W-1:0] want);
    logic [BYTES_W-1:0] readback;
    apb_transfer(1'b0, '0, readback);
    if (readback !== want) begin
      $error("byte_budget: expected %0h, got %0h", want, readback);
      error_count++;
    end
  endtask

  // Change the budget only once the cache has gone quiet.
  task automatic program_budget(input logic [BYTES_W-1:0] value);
    logic [BYTES_W-1:0] unused;
    wait_cache_idle();
    apb_transfer(1'b1, value, unused);
    budget_model = value;
    check_budget_read(value);
  endtask

  // The budget register comes out of reset at its default.
  task automatic test_reset_budget();
    check_budget_read(BUDGET_RESET);
  endtask

  // Zero budget: first insert into an empty table, then inserts that each evict the previous entry.
  task automatic test_over_budget_eviction();
    program_budget('0);
    send_lookup(16'h0000, 20'hFFFFF, 1'b1);
    send_lookup(16'hFFFF, 20'h00000, 1'b1);
    send_lookup(16'h1234, 20'h00005, 1'b1);
    send_lookup(16'h5555, 20'hAAAAA, 1'b1);
  endtask

  // Hits ignore size and render flag; failed renders leave the cache alone.
  task automatic test_hits_and_failed_renders();
    program_budget('1);
    send_lookup(16'h5555, 20'hFFFFF, 1'b0);
    send_lookup(16'hAAAA, 20'h55555, 1'b0);
    send_lookup(16'hAAAA, 20'h55555, 1'b1);
    send_lookup(16'h0F0F, 20'h00001, 1'b1);
    send_lookup(16'h5555, 20'h00000, 1'b1);
    send_lookup(16'hAAAA, 20'h12345, 1'b0);
    send_lookup(16'hF0F0, 20'h00000, 1'b0);
    send_lookup(16'h0F0F, 20'hFFFFF, 1'b1);
  endtask

  // Fill the table to the budget exactly, so that further inserts are both full and over.
  task automatic test_full_table();
    program_budget(32'd6400);
    for (int i = 0; i < ENTRIES + 6; i++) send_lookup(TAG_W'(16'h0100 + i), 20'd100, 1'b1);
    send_lookup(16'h0110, 20'd100, 1'b1);
    // With an unlimited budget only the full table forces the eviction.
    program_budget('1);
    send_lookup(16'h0200, 20'd7, 1'b1);
  endtask

  // Random lookups, mostly from a small pool of glyphs so that hits and reordering are common.
  task automatic test_random_traffic(input logic [BYTES_W-1:0] budget, input int idle,
                                     input int pool);
    logic [TAG_W-1:0] base;
    logic [TAG_W-1:0] glyph;
    logic [SIZE_W-1:0] nbytes;
    int pick;
    program_budget(budget);
    idle_pct = idle;
    base = TAG_W'($urandom_range(0, 65535 - pool));
    repeat (RANDOM_ITEMS) begin
      glyph = ($urandom_range(0, 9) < 7) ? TAG_W'(base + $urandom_range(0, pool - 1))
                                         : TAG_W'($urandom_range(0, 65535));
      pick = $urandom_range(0, 19);
      if (pick < 14) nbytes = SIZE_W'($urandom_range(0, 4095));
      else if (pick < 17) nbytes = SIZE_W'($urandom_range(0, 65535));
      else if (pick < 19) nbytes = SIZE_W'($urandom_range(0, 20'hFFFFF));
      else nbytes = $urandom_range(0, 1) ? 20'hFFFFF : 20'h00000;
      send_lookup(glyph, nbytes, $urandom_range(0, 9) != 0);
    end
  endtask

  // Check each result against the oldest prediction.
  always @(posedge clk_i) begin
    lookup_result_t exp;
    if (rst_ni && done_o) begin
      if (expected_lookups.size() == 0) begin
        $error("result with no item outstanding");
        error_count++;
      end else begin
        exp = expected_lookups.pop_front();
        if (hit_o !== exp.hit) begin
          $error("hit: expected %0h, got %0h", exp.hit, hit_o);
          error_count++;
        end
        if (inserted_o !== exp.inserted) begin
          $error("inserted: expected %0h, got %0h", exp.inserted, inserted_o);
          error_count++;
        end
        if (evicted_o !== exp.evicted) begin
          $error("evicted: expected %0h, got %0h", exp.evicted, evicted_o);
          error_count++;
        end
        if (evicted_index_o !== exp.evicted_index) begin
          $error("evicted_index: expected %0h, got %0h", exp.evicted_index, evicted_index_o);
          error_count++;
        end
        if (bytes_used_o !== exp.bytes_used) begin
          $error("bytes_used: expected %0h, got %0h", exp.bytes_used, bytes_used_o);
          error_count++;
        end
        if (entry_count_o !== exp.entry_count) begin
          $error("entry_count: expected %0h, got %0h", exp.entry_count, entry_count_o);
          error_count++;
        end
      end
    end
  end

  // Watchdog on cycles in which nothing moves on any port.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || done_o || (psel && penable && pready)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("byte_budget_lru_cache regression: fail");
        $finish;
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_budget();
    test_over_budget_eviction();
    test_hits_and_failed_renders();
    test_full_table();
    test_random_traffic('1, 0, 96);
    test_random_traffic('0, 100, 8);
    test_random_traffic($urandom_range(20000, 200000), 30, 80);
    test_random_traffic(BUDGET_RESET, 100, 96);
    test_random_traffic($urandom, 30, 72);
    test_random_traffic($urandom_range(1, 8192), 0, 40);
    wait_cache_idle();
    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("byte_budget_lru_cache regression: pass");
    end else begin
      $display("byte_budget_lru_cache regression: fail");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/bblru_pkg.sv
rtl/core/bblru_cell.sv
rtl/core/byte_budget_lru_cache.sv
rtl/core/bblru_checker.sv
dv/byte_budget_lru_cache_test.sv
